// ===== src/assert_macros.svh =====
// assertion macros used by the frame parser module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FRR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRR_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FRR_ASSERT(lbl, clk, rst, prop, msg)
`define FRR_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== src/frr_pkg.sv =====
// types and constants of the framed response receiver
package frr_pkg;

   localparam int unsigned MAX_DATA     = 8;
   localparam int unsigned COUNT_W      = $clog2(MAX_DATA + 1);
   localparam int unsigned FIRST_DATA_N = 3;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned TICK_W       = 16;

   localparam logic [BYTE_W-1:0]  MAX_LEN    = BYTE_W'(MAX_DATA);
   localparam logic [BYTE_W-1:0]  STATUS_LEN = BYTE_W'(FIRST_DATA_N);
   localparam logic [COUNT_W-1:0] FIRST_N_C  = COUNT_W'(FIRST_DATA_N);

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // result codes
   localparam logic [2:0] RC_OK        = 3'd0;
   localparam logic [2:0] RC_TOO_LONG  = 3'd1;
   localparam logic [2:0] RC_BAD_END   = 3'd2;
   localparam logic [2:0] RC_BAD_CHECK = 3'd3;
   localparam logic [2:0] RC_TIMEOUT   = 3'd4;

   // register indexes
   localparam logic [1:0] REG_START_BYTE  = 2'd0;
   localparam logic [1:0] REG_END_BYTE    = 2'd1;
   localparam logic [1:0] REG_STATUS_CMD  = 2'd2;
   localparam logic [1:0] REG_TIMEOUT     = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_CMD,
      PH_DATA,
      PH_CHK,
      PH_END
   } phase_type;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [BYTE_W-1:0] status_command;
      logic [TICK_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        result_code;
      logic [BYTE_W-1:0] command_code;
      logic [BYTE_W-1:0] frame_length;
      logic              status_valid;
      logic [BYTE_W-1:0] fan_speed;
      logic [BYTE_W-1:0] valve_state;
      logic [BYTE_W-1:0] siren_state;
   } result_type;

endpackage

// ===== src/framed_response_receiver_unit.sv =====
// framed response receiver: start/end framed byte parser with xor checksum
//
// req channel carries one beat per received uart byte or millisecond tick:
// tuser is the kind (0 byte, 1 tick) and tdata the byte. the parser hunts
// for the start byte, then takes length, command, data, checksum and end
// byte. a result beat on the rsp channel reports each finished frame: ok,
// length too long (right after the command byte), bad end byte, bad
// checksum, or a timeout when the tick gap inside a frame exceeds the limit.
// a request beat passes through the input register, then through the
// parser into the result register. one beat is accepted every cycle while
// no result waits on a stalled rsp channel; the parser state registers
// feed back through the parser logic.
// when the receiver holds rsp_tready low with a result waiting, the input
// register takes one more beat only if it is empty, then req_tready stays
// low until the result is taken. reset puts the parser back to hunting,
// empties both registers and loads the default register values (start 2,
// end 3, status command 0, timeout 100 ticks). the user must write the
// registers through the csr port while the block is idle; no check exists.
module framed_response_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // command (item kind)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // command_code, frame_length, fan_speed, valve_state, siren_state
   output logic [3:0]  rsp_tuser,   // result_code, status_valid
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   frr_pkg::cfg_type    cfg;
   frr_pkg::item_type   req_item;
   frr_pkg::item_type   item;
   frr_pkg::result_type result;
   frr_pkg::result_type rsp_result;
   logic                item_valid;
   logic                take;
   logic                step;
   logic                res_valid;

   assign req_item.command = req_tuser;
   assign req_item.rx_byte = req_tdata;
   assign step             = item_valid && take;

   frr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   frr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .result    (result)
   );

   frr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res_valid  (res_valid),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.siren_state, rsp_result.valve_state, rsp_result.fan_speed,
                       rsp_result.frame_length, rsp_result.command_code};
   assign rsp_tuser = {rsp_result.status_valid, rsp_result.result_code};

endmodule

// ===== src/frr_csr.sv =====
// configuration registers of the framed response receiver
module frr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [frr_pkg::TICK_W-1:0]    csr_wdata,
   output frr_pkg::cfg_type              cfg
);

   frr_pkg::cfg_type cfg_ff;
   frr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            frr_pkg::REG_START_BYTE: cfg_in.start_byte     = csr_wdata[frr_pkg::BYTE_W-1:0];
            frr_pkg::REG_END_BYTE:   cfg_in.end_byte       = csr_wdata[frr_pkg::BYTE_W-1:0];
            frr_pkg::REG_STATUS_CMD: cfg_in.status_command = csr_wdata[frr_pkg::BYTE_W-1:0];
            frr_pkg::REG_TIMEOUT:    cfg_in.timeout_ticks  = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= 8'd2;
         cfg_ff.end_byte       <= 8'd3;
         cfg_ff.status_command <= 8'd0;
         cfg_ff.timeout_ticks  <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/frr_in_stage.sv =====
// input register stage: holds one received beat until the parser takes it
module frr_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  frr_pkg::item_type  req_item,
   input  logic               take,
   output logic               item_valid,
   output frr_pkg::item_type  item
);

   logic              valid_ff;
   logic              valid_in;
   frr_pkg::item_type item_ff;
   logic              load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/frr_parser.sv =====
// frame parser: state machine over bytes and ticks, one beat per step
`include "assert_macros.svh"

module frr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  frr_pkg::cfg_type     cfg,
   input  logic                 step,
   input  frr_pkg::item_type    item,
   output logic                 res_valid,
   output frr_pkg::result_type  result
);

   frr_pkg::phase_type                phase_ff, phase_in;
   logic [frr_pkg::BYTE_W-1:0]        len_ff, len_in;
   logic [frr_pkg::BYTE_W-1:0]        cmd_ff, cmd_in;
   logic [frr_pkg::BYTE_W-1:0]        xor_ff, xor_in;
   logic [frr_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [frr_pkg::BYTE_W-1:0]        data_ff [frr_pkg::FIRST_DATA_N];
   logic [frr_pkg::BYTE_W-1:0]        data_in [frr_pkg::FIRST_DATA_N];
   logic [frr_pkg::BYTE_W-1:0]        check_ff, check_in;
   logic [frr_pkg::TICK_W-1:0]        gap_ff, gap_in;
   logic [2:0]                        res_code;
   logic                              status_ok;
   logic [frr_pkg::BYTE_W-1:0]        b;

   assign b = item.rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      xor_in    = xor_ff;
      count_in  = count_ff;
      data_in   = data_ff;
      check_in  = check_ff;
      gap_in    = gap_ff;
      res_valid = 1'b0;
      res_code  = frr_pkg::RC_OK;
      status_ok = 1'b0;
      if (item.command == frr_pkg::KIND_TICK) begin
         // ticks only count while inside a frame
         if (phase_ff != frr_pkg::PH_HUNT) begin
            gap_in = (gap_ff == '1) ? gap_ff : gap_ff + 1'b1;
            if (gap_in > cfg.timeout_ticks) begin
               res_valid = 1'b1;
               res_code  = frr_pkg::RC_TIMEOUT;
               phase_in  = frr_pkg::PH_HUNT;
            end
         end
      end else begin
         gap_in = '0;
         unique case (phase_ff)
            frr_pkg::PH_HUNT: begin
               if (b == cfg.start_byte) begin
                  len_in   = '0;
                  cmd_in   = '0;
                  xor_in   = '0;
                  count_in = '0;
                  check_in = '0;
                  for (int i = 0; i < frr_pkg::FIRST_DATA_N; i++) begin
                     data_in[i] = '0;
                  end
                  phase_in = frr_pkg::PH_LEN;
               end
            end
            frr_pkg::PH_LEN: begin
               len_in   = b;
               phase_in = frr_pkg::PH_CMD;
            end
            frr_pkg::PH_CMD: begin
               cmd_in = b;
               xor_in = b;
               if (len_ff > frr_pkg::MAX_LEN) begin
                  res_valid = 1'b1;
                  res_code  = frr_pkg::RC_TOO_LONG;
                  phase_in  = frr_pkg::PH_HUNT;
               end else if (len_ff == '0) begin
                  phase_in = frr_pkg::PH_CHK;
               end else begin
                  phase_in = frr_pkg::PH_DATA;
               end
            end
            frr_pkg::PH_DATA: begin
               if (count_ff < frr_pkg::FIRST_N_C) begin
                  data_in[count_ff[1:0]] = b;
               end
               xor_in   = xor_ff ^ b;
               count_in = count_ff + 1'b1;
               if (frr_pkg::BYTE_W'(count_in) >= len_ff) begin
                  phase_in = frr_pkg::PH_CHK;
               end
            end
            frr_pkg::PH_CHK: begin
               check_in = b;
               phase_in = frr_pkg::PH_END;
            end
            frr_pkg::PH_END: begin
               res_valid = 1'b1;
               phase_in  = frr_pkg::PH_HUNT;
               // bad end byte wins over a bad checksum
               if (b != cfg.end_byte) begin
                  res_code = frr_pkg::RC_BAD_END;
               end else if (check_ff != xor_ff) begin
                  res_code = frr_pkg::RC_BAD_CHECK;
               end else begin
                  res_code  = frr_pkg::RC_OK;
                  status_ok = (cmd_ff == cfg.status_command) && (len_ff == frr_pkg::STATUS_LEN);
               end
            end
            default: begin
               phase_in = frr_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      result.result_code  = res_code;
      result.command_code = cmd_in;
      result.frame_length = len_in;
      result.status_valid = status_ok;
      result.fan_speed    = status_ok ? data_ff[0] : '0;
      result.valve_state  = status_ok ? data_ff[1] : '0;
      result.siren_state  = status_ok ? data_ff[2] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= frr_pkg::PH_HUNT;
         gap_ff   <= '0;
         count_ff <= '0;
         len_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         gap_ff   <= gap_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
         check_ff <= check_in;
         data_ff  <= data_in;
      end
   end

   `FRR_ASSERT(a_result_rehunts, clock, reset, step && res_valid |=> phase_ff == frr_pkg::PH_HUNT, "parser did not return to hunting after a result")
   `FRR_NEVER(a_count_below_len, clock, reset, phase_ff == frr_pkg::PH_DATA && frr_pkg::BYTE_W'(count_ff) >= len_ff, "data count reached frame length while in data phase")
   `FRR_NEVER(a_data_len_bound, clock, reset, phase_ff == frr_pkg::PH_DATA && (len_ff > frr_pkg::MAX_LEN || len_ff == '0), "data phase entered with a length out of range")
   `FRR_NEVER(a_status_only_ok, clock, reset, res_valid && result.status_valid && result.result_code != frr_pkg::RC_OK, "status reported on a failed frame")

endmodule

// ===== src/frr_out_stage.sv =====
// result register: holds one result beat until the receiver takes it
module frr_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 res_valid,
   input  frr_pkg::result_type  result,
   output logic                 take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output frr_pkg::result_type  rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   frr_pkg::result_type result_ff;
   logic                load;

   assign take = !valid_ff || rsp_tready;
   assign load = step && res_valid;

   always_comb begin
      if (take) begin
         valid_in = load;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== test/framed_response_receiver_checker.sv =====
// scoreboard for the framed response receiver: frame parser prediction and result comparison
module framed_response_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);

   frr_pkg::cfg_type    cfg;
   frr_pkg::phase_type  parse_phase;
   logic [7:0]          frame_len;
   logic [7:0]          frame_cmd;
   logic [7:0]          check_acc;
   logic [7:0]          got_check;
   logic [3:0]          data_seen;
   logic [7:0]          status_bytes [frr_pkg::FIRST_DATA_N];
   logic [15:0]         gap_ticks;
   frr_pkg::result_type pending_results [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h, wanted %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic close_frame(input logic [2:0] code, input logic status_ok);
      frr_pkg::result_type r;
      r.result_code  = code;
      r.command_code = frame_cmd;
      r.frame_length = frame_len;
      r.status_valid = status_ok;
      r.fan_speed    = status_ok ? status_bytes[0] : 8'h00;
      r.valve_state  = status_ok ? status_bytes[1] : 8'h00;
      r.siren_state  = status_ok ? status_bytes[2] : 8'h00;
      pending_results.push_back(r);
      parse_phase = frr_pkg::PH_HUNT;
   endtask

   task automatic parse_beat(input logic kind, input logic [7:0] b);
      if (kind == frr_pkg::KIND_TICK) begin
         // ticks only count while a frame is open
         if (parse_phase != frr_pkg::PH_HUNT) begin
            if (gap_ticks != 16'hFFFF) begin
               gap_ticks++;
            end
            if (gap_ticks > cfg.timeout_ticks) begin
               close_frame(frr_pkg::RC_TIMEOUT, 1'b0);
            end
         end
      end else begin
         gap_ticks = '0;
         case (parse_phase)
            frr_pkg::PH_HUNT: begin
               if (b == cfg.start_byte) begin
                  frame_len   = '0;
                  frame_cmd   = '0;
                  check_acc   = '0;
                  data_seen   = '0;
                  got_check   = '0;
                  foreach (status_bytes[i]) status_bytes[i] = '0;
                  parse_phase = frr_pkg::PH_LEN;
               end
            end
            frr_pkg::PH_LEN: begin
               frame_len   = b;
               parse_phase = frr_pkg::PH_CMD;
            end
            frr_pkg::PH_CMD: begin
               frame_cmd = b;
               check_acc = b;
               if (frame_len > frr_pkg::MAX_LEN) begin
                  close_frame(frr_pkg::RC_TOO_LONG, 1'b0);
               end else if (frame_len == 8'h00) begin
                  parse_phase = frr_pkg::PH_CHK;
               end else begin
                  parse_phase = frr_pkg::PH_DATA;
               end
            end
            frr_pkg::PH_DATA: begin
               if (data_seen < frr_pkg::FIRST_DATA_N) begin
                  status_bytes[data_seen[1:0]] = b;
               end
               check_acc ^= b;
               data_seen++;
               if (data_seen >= frame_len) begin
                  parse_phase = frr_pkg::PH_CHK;
               end
            end
            frr_pkg::PH_CHK: begin
               got_check   = b;
               parse_phase = frr_pkg::PH_END;
            end
            frr_pkg::PH_END: begin
               // a bad end byte wins over a bad checksum
               if (b != cfg.end_byte) begin
                  close_frame(frr_pkg::RC_BAD_END, 1'b0);
               end else if (got_check != check_acc) begin
                  close_frame(frr_pkg::RC_BAD_CHECK, 1'b0);
               end else begin
                  close_frame(frr_pkg::RC_OK,
                              frame_cmd == cfg.status_command &&
                              frame_len == frr_pkg::STATUS_LEN);
               end
            end
            default: begin
               parse_phase = frr_pkg::PH_HUNT;
            end
         endcase
      end
   endtask

   task automatic check_result();
      frr_pkg::result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result beat with nothing pending, code", rsp_tuser[2:0], 0);
      end else begin
         want = pending_results.pop_front();
         check_field("result_code", 8'(rsp_tuser[2:0]), 8'(want.result_code));
         check_field("status_valid", 8'(rsp_tuser[3]), 8'(want.status_valid));
         check_field("command_code", rsp_tdata[7:0], want.command_code);
         check_field("frame_length", rsp_tdata[15:8], want.frame_length);
         check_field("fan_speed", rsp_tdata[23:16], want.fan_speed);
         check_field("valve_state", rsp_tdata[31:24], want.valve_state);
         check_field("siren_state", rsp_tdata[39:32], want.siren_state);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.start_byte     = 8'd2;
         cfg.end_byte       = 8'd3;
         cfg.status_command = 8'd0;
         cfg.timeout_ticks  = 16'd100;
         parse_phase        = frr_pkg::PH_HUNT;
         frame_len          = '0;
         frame_cmd          = '0;
         check_acc          = '0;
         got_check          = '0;
         data_seen          = '0;
         gap_ticks          = '0;
         foreach (status_bytes[i]) status_bytes[i] = '0;
         pending_results.delete();
         fail_count         = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               frr_pkg::REG_START_BYTE: cfg.start_byte     = csr_wdata[7:0];
               frr_pkg::REG_END_BYTE:   cfg.end_byte       = csr_wdata[7:0];
               frr_pkg::REG_STATUS_CMD: cfg.status_command = csr_wdata[7:0];
               frr_pkg::REG_TIMEOUT:    cfg.timeout_ticks  = csr_wdata;
               default: ;
            endcase
         end
         // a result beat stems from an earlier request that passed the input and result registers, so compare first
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            parse_beat(req_tuser, req_tdata);
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== test/tb_framed_response_receiver_unit.sv =====
// testbench top: stimulus, back-pressure and verdict for the framed response receiver
module tb_framed_response_receiver_unit;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_BEATS  = 1050;
   localparam int RANDOM_PHASES = 5;
   localparam int SETTLE_CYCLES = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = frr_pkg::KIND_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = frr_pkg::REG_START_BYTE;
   logic [15:0] csr_wdata  = '0;

   int               fail_count;
   int               outstanding;
   int               cycle_count = 0;
   int               beats_sent  = 0;
   int               tick_pct    = 0;
   int               ready_hold  = 0;
   int               ready_pick;
   int               phase_idx;
   bit               gap_free    = 1'b0;
   frr_pkg::cfg_type cfg;

   framed_response_receiver_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   framed_response_receiver_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result back-pressure: short stalls mostly, a few long ones, some stall-free stretches
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 45) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 3);
         end else if (ready_pick < 60) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(20, 80);
         end else if (ready_pick < 90) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
         end else if (ready_pick < 98) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(3, 10);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(20, 50);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gap_free || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_beat(input logic kind, input logic [7:0] b, input bit counted);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counted) beats_sent++;
   endtask

   // optional run of ticks between two frame bytes, sometimes just past the timeout
   task automatic tick_gap(output bit expired);
      int n;
      int r;
      expired = 1'b0;
      if ($urandom_range(0, 99) >= tick_pct) return;
      r = $urandom_range(0, 5);
      if (r == 0 && cfg.timeout_ticks <= 200) begin
         n = cfg.timeout_ticks + 1;
         expired = 1'b1;
      end else if (r == 1 && cfg.timeout_ticks <= 200) begin
         n = cfg.timeout_ticks;
      end else begin
         n = $urandom_range(1, (cfg.timeout_ticks < 3) ? cfg.timeout_ticks : 3);
      end
      repeat (n) send_beat(frr_pkg::KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   // payload bytes go out lowest first; cut stops the frame before that data byte
   task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                             input logic [63:0] payload, input logic [7:0] chk_flip,
                             input logic [7:0] end_flip, input int cut);
      logic [7:0] acc;
      bit         expired;
      int         i;
      send_beat(frr_pkg::KIND_BYTE, cfg.start_byte, 1'b1);
      tick_gap(expired);
      if (expired) return;
      send_beat(frr_pkg::KIND_BYTE, len, 1'b1);
      tick_gap(expired);
      if (expired) return;
      send_beat(frr_pkg::KIND_BYTE, cmd, 1'b1);
      if (len > frr_pkg::MAX_LEN) return;
      acc = cmd;
      for (i = 0; i < len; i++) begin
         if (i == cut) return;
         tick_gap(expired);
         if (expired) return;
         send_beat(frr_pkg::KIND_BYTE, payload[8*i +: 8], 1'b1);
         acc ^= payload[8*i +: 8];
      end
      tick_gap(expired);
      if (expired) return;
      send_beat(frr_pkg::KIND_BYTE, acc ^ chk_flip, 1'b1);
      tick_gap(expired);
      if (expired) return;
      send_beat(frr_pkg::KIND_BYTE, cfg.end_byte ^ end_flip, 1'b1);
   endtask

   task automatic random_frame();
      int          pick;
      int          i;
      logic [7:0]  len;
      logic [7:0]  cmd;
      logic [7:0]  b;
      logic [63:0] payload;
      pick     = $urandom_range(0, 99);
      gap_free = ($urandom_range(0, 4) == 0);
      // line noise and idle ticks ahead of the frame
      repeat ($urandom_range(0, 2)) begin
         b = 8'($urandom_range(0, 255));
         if (b == cfg.start_byte) b ^= 8'h01;
         send_beat(1'($urandom_range(0, 1)), b, 1'b1);
      end
      payload = {$urandom, $urandom};
      for (i = 0; i < 8; i++) begin
         if ($urandom_range(0, 15) == 0) payload[8*i +: 8] = cfg.start_byte;
      end
      cmd = 8'($urandom_range(0, 255));
      if (pick < 20) begin
         len = frr_pkg::STATUS_LEN;
         cmd = cfg.status_command;
      end else if (pick == 20) begin
         len = 8'hFF;
      end else if (pick < 28) begin
         len = 8'($urandom_range(frr_pkg::MAX_DATA + 1, 255));
      end else if (pick < 36) begin
         len = 8'h00;
      end else begin
         len = 8'($urandom_range(0, frr_pkg::MAX_DATA));
      end
      send_frame(len, cmd, payload,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                 ($urandom_range(0, 19) == 0) ? $urandom_range(0, frr_pkg::MAX_DATA - 1) : -1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // a frame byte that gives no result may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [7:0] sb, input logic [7:0] eb,
                              input logic [7:0] sc, input logic [15:0] tt);
      drain();
      csr_we    <= 1'b1;
      csr_index <= frr_pkg::REG_START_BYTE;
      csr_wdata <= {8'h00, sb};
      @(posedge clock);
      csr_index <= frr_pkg::REG_END_BYTE;
      csr_wdata <= {8'h00, eb};
      @(posedge clock);
      csr_index <= frr_pkg::REG_STATUS_CMD;
      csr_wdata <= {8'h00, sc};
      @(posedge clock);
      csr_index <= frr_pkg::REG_TIMEOUT;
      csr_wdata <= tt;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg.start_byte     = sb;
      cfg.end_byte       = eb;
      cfg.status_command = sc;
      cfg.timeout_ticks  = tt;
   endtask

   initial begin
      cfg.start_byte     = 8'd2;
      cfg.end_byte       = 8'd3;
      cfg.status_command = 8'd0;
      cfg.timeout_ticks  = 16'd100;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed frames on the reset register values
      send_beat(frr_pkg::KIND_BYTE, 8'h55, 1'b0);
      send_beat(frr_pkg::KIND_TICK, 8'h00, 1'b0);
      send_frame(8'd3, 8'h00, 64'h80_ff_00, 8'h00, 8'h00, -1);
      send_frame(8'd0, 8'h7f, 64'h0, 8'h7f, 8'h00, -1);
      send_frame(8'd9, 8'h11, 64'h0, 8'h00, 8'h00, -1);
      send_frame(8'd0, 8'h11, 64'h0, 8'h33, 8'hfc, -1);
      send_frame(8'd1, 8'h05, 64'h02, 8'h00, 8'h00, -1);

      // extreme register values and a short timeout
      load_config(8'h00, 8'hff, 8'hff, 16'd1);
      send_frame(8'd3, 8'hff, 64'h56_34_12, 8'h00, 8'h00, -1);
      send_frame(8'd255, 8'h01, 64'h0, 8'h00, 8'h00, -1);
      send_frame(8'd8, 8'ha5, 64'hff00_ff00_aa55_0f01, 8'h00, 8'h00, -1);
      send_beat(frr_pkg::KIND_BYTE, 8'h00, 1'b1);
      send_beat(frr_pkg::KIND_BYTE, 8'h01, 1'b1);
      send_beat(frr_pkg::KIND_TICK, 8'hff, 1'b1);
      send_beat(frr_pkg::KIND_TICK, 8'h00, 1'b1);

      load_config(8'hff, 8'h00, 8'h00, 16'hffff);
      send_frame(8'd3, 8'h01, 64'h0, 8'h00, 8'h00, -1);
      send_frame(8'd3, 8'h00, 64'hff_ff_ff, 8'h00, 8'h00, -1);

      tick_pct   = 12;
      beats_sent = 0;
      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)),
                     (phase_idx == 2) ? 16'd100 :
                     (phase_idx == 4) ? 16'($urandom_range(200, 65535)) :
                                        16'($urandom_range(1, 6)));
         while (beats_sent < RANDOM_BEATS * (phase_idx + 1) / RANDOM_PHASES) begin
            random_frame();
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== framed_response_receiver_unit.f =====
+incdir+src
src/frr_pkg.sv
src/frr_csr.sv
src/frr_in_stage.sv
src/frr_parser.sv
src/frr_out_stage.sv
src/framed_response_receiver_unit.sv
test/framed_response_receiver_checker.sv
test/tb_framed_response_receiver_unit.sv
